FILE: design/imh_pkg.sv
// shared types, constants and codes for the indexed min-heap fixer
package imh_pkg;
  localparam int DEPTH = 256;
  localparam int KEY_BITS = 64;
  localparam int TAG_BITS = 16;
  localparam int POS_BITS = 8;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_UPDATE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic action;
    logic [7:0] position;
    logic [63:0] new_key;
    logic [15:0] owner_tag;
  } in_item_t;

  typedef struct packed {
    logic [15:0] moved_tag;
    logic [7:0] new_position;
    logic [1:0] status;
    logic last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LASTRD, S_LASTWAIT, S_FIXRD, S_FIXWAIT,
    S_UPRD, S_UPWAIT, S_UPDEC, S_DNRD, S_DNWAIT, S_DNDEC, S_FINAL, S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd_last;
    logic take_last;
    logic rd_cur;
    logic rd_parent;
    logic rd_children;
    logic cap_rd;
    logic up_move;
    logic dn_move;
    logic fin_write;
    logic emit_moved;
    logic emit_final;
    logic emit_reject;
    logic emit_none;
    logic cnt_inc;
    logic cnt_dec;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic reject;
    logic append;
    logic remove_last;
    logic at_root;
    logic go_up;
    logic up_more;
    logic dn_more;
    logic has_child;
    logic out_busy;
  } sts_t;
endpackage

FILE: design/imh_ram.sv
// generic single-write dual-read ram with registered read
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH_W = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH_W)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH_W)-1:0] raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [$clog2(DEPTH_W)-1:0] raddr_b,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH_W];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

FILE: design/imh_datapath.sv
// heap storage, slot arithmetic, compares and result register
module imh_datapath (
  input  logic clk,
  input  logic rst,
  input  imh_pkg::in_item_t in_item,
  input  imh_pkg::cmd_t cmd,
  output imh_pkg::sts_t sts,
  output imh_pkg::out_item_t result,
  output logic result_valid,
  input  logic result_stall
);
  import imh_pkg::*;

  logic action;
  logic [ADDR_BITS:0] pos;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;
  logic [CNT_BITS-1:0] count;
  logic [KEY_BITS-1:0] ka, kb;
  logic [TAG_BITS-1:0] ta, tb;
  logic [KEY_BITS-1:0] keya_q, keyb_q;
  logic [TAG_BITS-1:0] taga_q, tagb_q;
  logic [ADDR_BITS:0] nxt;
  logic we;
  logic [ADDR_BITS-1:0] waddr, ra, rb;
  logic [KEY_BITS-1:0] wkey;
  logic [TAG_BITS-1:0] wtag;
  logic [ADDR_BITS+1:0] lc, rc;
  logic [ADDR_BITS-1:0] parent;
  logic pick_r;

  assign parent = ADDR_BITS'((pos - 1'b1) >> 1);
  assign lc = {pos, 1'b1};
  assign rc = {pos, 1'b0} + 2'd2;

  always_comb begin
    ra = pos[ADDR_BITS-1:0];
    rb = pos[ADDR_BITS-1:0];
    if (cmd.rd_last) begin
      ra = ADDR_BITS'(count);
    end else if (cmd.rd_parent || cmd.rd_cur) begin
      ra = parent;
    end else if (cmd.rd_children) begin
      ra = lc[ADDR_BITS-1:0];
      rb = rc[ADDR_BITS-1:0];
    end
  end

  imh_ram #(.WIDTH(KEY_BITS), .DEPTH_W(DEPTH)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wkey),
    .raddr_a(ra), .rdata_a(ka), .raddr_b(rb), .rdata_b(kb));
  imh_ram #(.WIDTH(TAG_BITS), .DEPTH_W(DEPTH)) u_tags (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wtag),
    .raddr_a(ra), .rdata_a(ta), .raddr_b(rb), .rdata_b(tb));

  // registered read data
  always_ff @(posedge clk) begin
    if (cmd.cap_rd) begin
      keya_q <= ka;
      keyb_q <= kb;
      taga_q <= ta;
      tagb_q <= tb;
    end
  end

  assign pick_r = (ADDR_BITS+2)'(count) > rc && keyb_q < keya_q;

  always_comb begin
    we = 1'b0;
    waddr = pos[ADDR_BITS-1:0];
    wkey = key;
    wtag = tag;
    if (cmd.up_move) begin
      we = 1'b1;
      wkey = keya_q;
      wtag = taga_q;
    end else if (cmd.dn_move) begin
      we = 1'b1;
      wkey = pick_r ? keyb_q : keya_q;
      wtag = pick_r ? tagb_q : taga_q;
    end else if (cmd.fin_write) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action <= in_item.action;
      pos <= {1'b0, in_item.position};
      key <= in_item.new_key;
      tag <= in_item.owner_tag;
    end else if (cmd.take_last) begin
      key <= ka;
      tag <= ta;
    end
    if (cmd.up_move) begin
      pos <= {1'b0, parent};
    end else if (cmd.dn_move) begin
      pos <= pick_r ? rc[ADDR_BITS:0] : lc[ADDR_BITS:0];
    end
  end
  assign nxt = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  always_comb begin
    sts.action = action;
    if (action == ACT_PLACE) begin
      sts.reject = (CNT_BITS+1)'(nxt) > (CNT_BITS+1)'(count) ||
                   (CNT_BITS+1)'(nxt) >= (CNT_BITS+1)'(DEPTH);
    end else begin
      sts.reject = (CNT_BITS+1)'(nxt) >= (CNT_BITS+1)'(count);
    end
    sts.append = (CNT_BITS+1)'(nxt) == (CNT_BITS+1)'(count);
    sts.remove_last = (CNT_BITS+1)'(nxt) + 1'b1 == (CNT_BITS+1)'(count);
    sts.at_root = nxt == '0;
    sts.go_up = ka > key;
    sts.up_more = !(key > keya_q);
    sts.has_child = (ADDR_BITS+2)'(count) > lc;
    sts.dn_more = (pick_r ? keyb_q : keya_q) < key;
    sts.out_busy = result_valid && result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_moved || cmd.emit_final || cmd.emit_reject || cmd.emit_none) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_moved) begin
      result <= '{moved_tag: wtag, new_position: pos[POS_BITS-1:0],
                  status: ST_UPDATE, last: 1'b0};
    end else if (cmd.emit_final) begin
      result <= '{moved_tag: tag, new_position: nxt[POS_BITS-1:0],
                  status: ST_UPDATE, last: 1'b1};
    end else if (cmd.emit_reject) begin
      result <= '{moved_tag: '0, new_position: '0, status: ST_REJECT, last: 1'b1};
    end else if (cmd.emit_none) begin
      result <= '{moved_tag: '0, new_position: '0, status: ST_NONE, last: 1'b1};
    end
  end
endmodule

FILE: design/imh_ctrl.sv
// sequencer for place, remove and sift steps
module imh_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  imh_pkg::sts_t sts,
  output imh_pkg::cmd_t cmd,
  output logic in_stall
);
  import imh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) state_next = S_CHECK;
      S_CHECK: begin
        if (!sts.out_busy) begin
          if (sts.reject) state_next = S_IDLE;
          else if (sts.action == ACT_REMOVE && sts.remove_last) state_next = S_IDLE;
          else if (sts.action == ACT_REMOVE) state_next = S_LASTRD;
          else state_next = S_FIXRD;
        end
      end
      S_LASTRD: state_next = S_LASTWAIT;
      S_LASTWAIT: state_next = S_FIXRD;
      S_FIXRD: state_next = sts.at_root ? S_DNRD : S_FIXWAIT;
      S_FIXWAIT: state_next = sts.go_up ? S_UPDEC : S_DNRD;
      S_UPRD: state_next = sts.at_root ? S_FINAL : S_UPWAIT;
      S_UPWAIT: state_next = S_UPDEC;
      S_UPDEC: if (!sts.out_busy) state_next = sts.up_more ? S_UPRD : S_FINAL;
      S_DNRD: state_next = sts.has_child ? S_DNWAIT : S_FINAL;
      S_DNWAIT: state_next = S_DNDEC;
      S_DNDEC: if (!sts.out_busy) state_next = sts.dn_more ? S_DNRD : S_FINAL;
      S_FINAL: state_next = S_EMIT;
      S_EMIT: if (!sts.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = state != S_IDLE;
    case (state)
      S_IDLE: cmd.load_in = in_fire;
      S_CHECK: begin
        if (!sts.out_busy) begin
          if (sts.reject) begin
            cmd.emit_reject = 1'b1;
          end else if (sts.action == ACT_REMOVE) begin
            cmd.cnt_dec = 1'b1;
            cmd.emit_none = sts.remove_last;
          end else begin
            cmd.cnt_inc = sts.append;
          end
        end
      end
      S_LASTRD: cmd.rd_last = 1'b1;
      S_LASTWAIT: cmd.take_last = 1'b1;
      S_FIXRD: cmd.rd_cur = 1'b1;
      S_FIXWAIT: cmd.cap_rd = 1'b1;
      S_UPRD: cmd.rd_parent = 1'b1;
      S_UPWAIT: cmd.cap_rd = 1'b1;
      S_UPDEC: begin
        if (!sts.out_busy && sts.up_more) begin
          cmd.up_move = 1'b1;
          cmd.emit_moved = 1'b1;
        end
      end
      S_DNRD: cmd.rd_children = 1'b1;
      S_DNWAIT: cmd.cap_rd = 1'b1;
      S_DNDEC: begin
        if (!sts.out_busy && sts.dn_more) begin
          cmd.dn_move = 1'b1;
          cmd.emit_moved = 1'b1;
        end
      end
      S_FINAL: cmd.fin_write = 1'b1;
      S_EMIT: cmd.emit_final = !sts.out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

FILE: design/indexed_min_heap_fixer.sv
// top level of the indexed min-heap fixer
// a reject or empty removal gives its result straight from the check; a repair reads, compares
// and moves one level per step; one transaction at a time, the next taken from the cycle in
// which the final result is shown; a stalled result holds the sequencer until it is taken
// reset clears the entry count, sequencer and output valid flag; heap ram contents are left as they are
module indexed_min_heap_fixer (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  imh_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output imh_pkg::out_item_t out_data
);
  import imh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  imh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && !in_stall),
    .sts(sts), .cmd(cmd), .in_stall(in_stall));

  imh_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .sts(sts),
    .result(out_data), .result_valid(out_valid), .result_stall(out_stall));
endmodule

FILE: design/imh_checker.sv
// port-level checks for the indexed min-heap fixer, bound to the top level
module imh_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input imh_pkg::out_item_t out_data
);
  import imh_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_UPDATE |-> out_data.last)
    else $error("reject or none not last");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted during work");
  a_rzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_REJECT |-> out_data.moved_tag == '0)
    else $error("reject carries a tag");
endmodule

bind indexed_min_heap_fixer imh_checker u_chk (.*);

FILE: bench/tb_top.sv
// testbench for the indexed min-heap fixer: random and directed heap traffic checked by a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import imh_pkg::*;

  class heap_scoreboard;
    logic [63:0] keys[DEPTH];
    logic [15:0] tags[DEPTH];
    int count;
    out_item_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void push(logic [15:0] tag, int slot, logic [1:0] st, logic fin);
      out_item_t r;
      r.moved_tag = tag;
      r.new_position = slot[7:0];
      r.status = st;
      r.last = fin;
      pending.push_back(r);
    endfunction

    function void sift_up(int slot);
      logic [63:0] k;
      logic [15:0] t;
      int up;
      k = keys[slot];
      t = tags[slot];
      while (slot > 0) begin
        up = (slot - 1) >> 1;
        if (k > keys[up]) break;
        keys[slot] = keys[up];
        tags[slot] = tags[up];
        push(tags[slot], slot, ST_UPDATE, 1'b0);
        slot = up;
      end
      keys[slot] = k;
      tags[slot] = t;
      push(t, slot, ST_UPDATE, 1'b1);
    endfunction

    function void sift_down(int slot);
      logic [63:0] k;
      logic [15:0] t;
      int lc, nx;
      k = keys[slot];
      t = tags[slot];
      forever begin
        lc = slot * 2 + 1;
        if (lc >= count) break;
        nx = lc;
        if (lc + 1 < count && keys[lc + 1] < keys[lc]) nx = lc + 1;
        if (keys[nx] >= k) break;
        keys[slot] = keys[nx];
        tags[slot] = tags[nx];
        push(tags[slot], slot, ST_UPDATE, 1'b0);
        slot = nx;
      end
      keys[slot] = k;
      tags[slot] = t;
      push(t, slot, ST_UPDATE, 1'b1);
    endfunction

    function void fix_slot(int slot);
      if (slot > 0 && keys[(slot - 1) >> 1] > keys[slot]) sift_up(slot);
      else sift_down(slot);
    endfunction

    function void note_input(in_item_t it);
      int p;
      p = it.position;
      if (it.action == ACT_PLACE) begin
        if (p > count || p >= DEPTH) begin
          push(16'd0, 0, ST_REJECT, 1'b1);
          return;
        end
        if (p == count) count++;
        keys[p] = it.new_key;
        tags[p] = it.owner_tag;
        fix_slot(p);
      end else begin
        if (p >= count) begin
          push(16'd0, 0, ST_REJECT, 1'b1);
          return;
        end
        count--;
        if (p == count) begin
          push(16'd0, 0, ST_NONE, 1'b1);
          return;
        end
        keys[p] = keys[count];
        tags[p] = tags[count];
        fix_slot(p);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.moved_tag !== e.moved_tag || got.new_position !== e.new_position ||
          got.status !== e.status || got.last !== e.last) begin
        $display("%0t mismatch expected tag %h pos %0d st %0d last %0d",
                 $realtime, e.moved_tag, e.new_position, e.status, e.last,
                 " actual tag %h pos %0d st %0d last %0d",
                 got.moved_tag, got.new_position, got.status, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  heap_scoreboard sb = new();
  bit calm = 1'b0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  indexed_min_heap_fixer dut (.*);

  always #2 clk = ~clk;

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= roll_idle();
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) timed_out <= 1'b1;
    end
  end

  task automatic send(logic act, logic [7:0] pos, logic [63:0] k, logic [15:0] t);
    in_item_t it;
    while (roll_idle()) @(posedge clk);
    it.action = act;
    it.position = pos;
    it.new_key = k;
    it.owner_tag = t;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    case ($urandom_range(3))
      0: return 64'd0;
      1: return '1;
      2: return {32'd0, 28'd0, 4'($urandom_range(15))};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_stimulus();
    int c, n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(ACT_REMOVE, 8'd0, '0, '0);
    send(ACT_PLACE, 8'd1, '0, '0);
    send(ACT_PLACE, 8'd0, 64'd50, 16'hffff);
    send(ACT_PLACE, 8'd1, 64'd50, 16'h0001);
    send(ACT_PLACE, 8'd2, '1, 16'h0002);
    send(ACT_PLACE, 8'd3, 64'd0, 16'h0003);
    send(ACT_PLACE, 8'd4, 64'd7, 16'h0004);
    send(ACT_PLACE, 8'd1, '1, 16'h0005);
    send(ACT_PLACE, 8'd0, 64'd3, 16'h0006);
    send(ACT_REMOVE, 8'd4, '0, '0);
    send(ACT_REMOVE, 8'd0, '0, '0);
    send(ACT_REMOVE, 8'd9, '0, '0);
    send(ACT_PLACE, 8'hff, '1, '1);
    drain();
    // grow a deep heap without idling, then poke past the end
    calm = 1'b1;
    while (sb.count < 64)
      send(ACT_PLACE, sb.count[7:0], rand_key(), 16'($urandom));
    send(ACT_PLACE, 8'hff, 64'd0, 16'h1234);
    send(ACT_PLACE, 8'd200, 64'd0, 16'h4321);
    send(ACT_REMOVE, 8'hff, '0, '0);
    calm = 1'b0;
    drain();
    for (int i = 0; i < 45; i++) begin
      c = sb.count;
      n = $urandom_range(9);
      if (i == 20) drain();
      if (n < 4 && c < DEPTH) send(ACT_PLACE, c[7:0], rand_key(), 16'($urandom));
      else if (n < 6 && c > 0) send(ACT_PLACE, 8'($urandom_range(c - 1)), rand_key(),
                                    16'($urandom));
      else if (n < 8 && c > 0) send(ACT_REMOVE, 8'($urandom_range(c - 1)), 64'($urandom),
                                    16'($urandom));
      else send(1'($urandom), 8'($urandom), {$urandom, $urandom}, 16'($urandom));
    end
    drain();
    repeat (40) @(posedge clk);
  endtask

  initial begin
    fork
      run_stimulus();
      wait (timed_out);
    join_any
    if (!timed_out && sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS indexed_min_heap_fixer");
    end else begin
      $display("FAIL indexed_min_heap_fixer");
    end
    $finish;
  end
endmodule
